/* rtl/ifla_pkg.sv */
// Shared types and constants for the index free-list allocator.
// No dependencies; every other file refers to it by scoped names.
package ifla_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LINK_W    = SLOT_W + 1;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // End-of-list mark: one past the highest slot number
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_SLOTS);

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_ALL  = 1'b1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_LOCKED  = 2'd2,
    STS_IGNORED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Write request into the slot store: allocated mark and next link
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              mark;
    logic [LINK_W-1:0] data;
  } link_wr_t;

endpackage

/* rtl/ifla_req_if.sv */
// Request channel of the index free-list allocator: valid/ready plus payload.
// Depends on ifla_pkg.
interface ifla_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ifla_pkg::SLOT_W-1:0] slot_in;

  modport source (output valid, output operation, output slot_in, input ready);
  modport sink   (input valid, input operation, input slot_in, output ready);
endinterface

/* rtl/ifla_rsp_if.sv */
// Response channel of the index free-list allocator: valid/ready plus payload.
// Depends on ifla_pkg.
interface ifla_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ifla_pkg::SLOT_W-1:0] slot_out;
  logic [1:0]                  status;
  logic [ifla_pkg::LINK_W-1:0] free_slots;

  modport source (output valid, output slot_out, output status, output free_slots,
                  input ready);
  modport sink   (input valid, input slot_out, input status, input free_slots,
                  output ready);
endinterface

/* rtl/ifla_link_store.sv */
// Slot memory of the free list (allocated mark and next link), registered read.
// Per-entry written bits stand in for the rebuilt chain and cleared marks; depends on ifla_pkg.
module ifla_link_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic [ifla_pkg::LINK_W-1:0] pool_n,
  input  logic                        rd_en,
  input  logic [ifla_pkg::SLOT_W-1:0] rd_addr,
  input  ifla_pkg::link_wr_t          wr,
  output logic [ifla_pkg::LINK_W-1:0] rd_link,
  output logic                        rd_mark
);

  logic [ifla_pkg::LINK_W:0]      ram [ifla_pkg::MAX_SLOTS];
  logic [ifla_pkg::MAX_SLOTS-1:0] written;
  logic [ifla_pkg::LINK_W:0]      ram_q;
  logic                           written_q;
  logic [ifla_pkg::SLOT_W-1:0]    addr_q;
  logic [ifla_pkg::LINK_W-1:0]    addr_ext;
  logic [ifla_pkg::LINK_W-1:0]    chain_link;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram[wr.addr] <= {wr.mark, wr.data};
    end
    if (rd_en) begin
      ram_q <= ram[rd_addr];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  // Entries untouched since the last rebuild follow the chain 0 -> 1 -> ... -> N-1
  // and are not allocated
  assign addr_ext   = ifla_pkg::LINK_W'(addr_q);
  assign chain_link = (addr_ext == pool_n - ifla_pkg::LINK_W'(1)) ? ifla_pkg::LINK_END
                                                                  : addr_ext + ifla_pkg::LINK_W'(1);
  assign rd_link    = written_q ? ram_q[ifla_pkg::LINK_W-1:0] : chain_link;
  assign rd_mark    = written_q && ram_q[ifla_pkg::LINK_W];

endmodule

/* rtl/index_free_list_allocator.sv */
// Index free-list allocator: LIFO pool of slot numbers with links in memory.
// Depends on ifla_pkg, ifla_req_if, ifla_rsp_if and ifla_link_store.
//
// Usage
//   req carries one operation per transfer: allocate (slot_in ignored) or
//   release of slot_in. rsp returns exactly one result per request: the
//   allocated slot, a status code and the free count after the operation.
//   cfg_we/cfg_index/cfg_data write pool_size (index 0) or lock_all (index 1);
//   a pool_size write saturates at 256 and rebuilds the free list in the
//   same cycle, forgetting all outstanding allocations. Write config only
//   while no request is in flight.
// Sequence
//   A request is taken in the idle state, where the slot memory entry (the head
//   slot for allocate, slot_in for release) is read; the exec state then updates
//   head, count and the entry and loads the response register, waiting there
//   while the response register still holds an unaccepted result.
//   A new request is taken only in the idle state, once the last one is done.
// Reset and stall
//   Synchronous rst sets pool_size 256, lock_all 0 and the full chain 0..255;
//   no clearing pass is needed. While rsp is stalled the block holds the
//   finished result and accepts one more request, which waits in its update
//   cycle until the response register frees up.
module index_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst,
  ifla_req_if.sink                       req,
  ifla_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [ifla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ifla_pkg::CFG_W-1:0]     cfg_data
);

  ifla_pkg::state_t state, state_next;

  logic [ifla_pkg::LINK_W-1:0]    pool_n;
  logic                           lock_all;
  logic [ifla_pkg::LINK_W-1:0]    head;
  logic [ifla_pkg::LINK_W-1:0]    free_total;
  logic                           op_q;
  logic [ifla_pkg::SLOT_W-1:0]    slot_q;

  logic                           rsp_valid;
  logic [ifla_pkg::SLOT_W-1:0]    rsp_slot;
  ifla_pkg::status_t              rsp_status;
  logic [ifla_pkg::LINK_W-1:0]    rsp_free;

  logic                           req_xfer;
  logic                           done;
  logic                           out_free;
  logic                           rebuild;
  logic [ifla_pkg::LINK_W-1:0]    pool_sat;
  logic [ifla_pkg::SLOT_W-1:0]    rd_addr;
  logic [ifla_pkg::LINK_W-1:0]    link;
  logic                           slot_mark;
  logic                           alloc_ok;
  logic                           rel_ok;
  ifla_pkg::link_wr_t             link_wr;

  assign req_xfer = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign rebuild  = cfg_we && (cfg_index == ifla_pkg::REG_POOL_SIZE);
  assign pool_sat = (cfg_data > ifla_pkg::CFG_W'(ifla_pkg::MAX_SLOTS))
                    ? ifla_pkg::LINK_W'(ifla_pkg::MAX_SLOTS)
                    : ifla_pkg::LINK_W'(cfg_data);

  assign alloc_ok = !lock_all && (pool_n != '0) && (free_total != '0) && (head < pool_n);
  assign rel_ok   = (ifla_pkg::LINK_W'(slot_q) < pool_n) && slot_mark;

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    done       = 1'b0;
    case (state)
      ifla_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ifla_pkg::ST_EXEC;
        end
      end
      ifla_pkg::ST_EXEC: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ifla_pkg::ST_IDLE;
        end
      end
      default: state_next = ifla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write back: allocate keeps the head's link and sets its mark;
  // release links the slot to the old head and clears its mark
  always_comb begin
    link_wr.en   = 1'b0;
    link_wr.addr = slot_q;
    link_wr.mark = 1'b0;
    link_wr.data = head;
    if (done) begin
      if (op_q == ifla_pkg::OP_ALLOC) begin
        link_wr.en   = alloc_ok;
        link_wr.addr = head[ifla_pkg::SLOT_W-1:0];
        link_wr.mark = 1'b1;
        link_wr.data = link;
      end else begin
        link_wr.en = rel_ok;
      end
    end
  end

  assign rd_addr = (req.operation == ifla_pkg::OP_RELEASE) ? req.slot_in
                                                           : head[ifla_pkg::SLOT_W-1:0];

  ifla_link_store u_link_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (rebuild),
    .pool_n  (pool_n),
    .rd_en   (req_xfer),
    .rd_addr (rd_addr),
    .wr      (link_wr),
    .rd_link (link),
    .rd_mark (slot_mark)
  );

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_q   <= req.operation;
      slot_q <= req.slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_n     <= ifla_pkg::LINK_W'(ifla_pkg::MAX_SLOTS);
      lock_all   <= 1'b0;
      head       <= '0;
      free_total <= ifla_pkg::LINK_W'(ifla_pkg::MAX_SLOTS);
    end else if (rebuild) begin
      pool_n     <= pool_sat;
      head       <= (pool_sat != '0) ? '0 : ifla_pkg::LINK_END;
      free_total <= pool_sat;
    end else begin
      if (cfg_we && (cfg_index == ifla_pkg::REG_LOCK_ALL)) begin
        lock_all <= cfg_data[0];
      end
      if (done) begin
        if (op_q == ifla_pkg::OP_ALLOC) begin
          if (alloc_ok) begin
            head       <= link;
            free_total <= free_total - ifla_pkg::LINK_W'(1);
          end
        end else if (rel_ok) begin
          head       <= ifla_pkg::LINK_W'(slot_q);
          free_total <= free_total + ifla_pkg::LINK_W'(1);
        end
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_slot <= '0;
      if (op_q == ifla_pkg::OP_ALLOC) begin
        if (lock_all) begin
          rsp_status <= ifla_pkg::STS_LOCKED;
          rsp_free   <= free_total;
        end else if (alloc_ok) begin
          rsp_status <= ifla_pkg::STS_OK;
          rsp_slot   <= head[ifla_pkg::SLOT_W-1:0];
          rsp_free   <= free_total - ifla_pkg::LINK_W'(1);
        end else begin
          rsp_status <= ifla_pkg::STS_EMPTY;
          rsp_free   <= free_total;
        end
      end else if (rel_ok) begin
        rsp_status <= ifla_pkg::STS_OK;
        rsp_free   <= free_total + ifla_pkg::LINK_W'(1);
      end else begin
        rsp_status <= ifla_pkg::STS_IGNORED;
        rsp_free   <= free_total;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.slot_out   = rsp_slot;
  assign rsp.status     = rsp_status;
  assign rsp.free_slots = rsp_free;

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= pool_n)
    else $error("free count exceeds pool size");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    head != ifla_pkg::LINK_END |-> head < pool_n)
    else $error("list head outside pool");

  a_empty_head_end: assert property (@(posedge clk) disable iff (rst)
    free_total == '0 |-> head == ifla_pkg::LINK_END)
    else $error("empty list with live head");

  a_rsp_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ifla_pkg::ST_EXEC))
    else $error("response without an update cycle");

endmodule
